// File: sv/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dq_pkg.sv
// Shared constants, types and codes for the double-ended queue.
package dq_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 5;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = ((WORD_W + OCC_W + 7) / 8) * 8;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          cell_cmd_t;

    // request modes
    localparam mode_t MODE_PUSH_REAR  = 2'd0;
    localparam mode_t MODE_PUSH_FRONT = 2'd1;
    localparam mode_t MODE_POP_REAR   = 2'd2;
    localparam mode_t MODE_POP_FRONT  = 2'd3;

    // result status
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // per-cell update command
    localparam cell_cmd_t CMD_HOLD       = 2'd0;
    localparam cell_cmd_t CMD_LOAD       = 2'd1;
    localparam cell_cmd_t CMD_TAKE_LEFT  = 2'd2;
    localparam cell_cmd_t CMD_TAKE_RIGHT = 2'd3;

    typedef struct packed {
        cell_cmd_t cmd;     // update for this cycle
        logic      rd_sel;  // cell drives the rear read bus
    } cell_ctrl_t;

endpackage

// File: sv/dq_cell.sv
// One storage cell of the deque shift chain.
module dq_cell
    import dq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      load_data,
    input  word_t      left_data,
    input  word_t      right_data,
    output word_t      data,
    output word_t      rd_data
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        case (ctrl.cmd)
            CMD_LOAD:       data_next = load_data;
            CMD_TAKE_LEFT:  data_next = left_data;
            CMD_TAKE_RIGHT: data_next = right_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = data_reg & {WORD_W{ctrl.rd_sel}};

endmodule

// File: sv/double_ended_queue.sv
// Top level of the double-ended queue: request decode, cell chain and result register.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the mode (push rear,
//   push front, pop rear, pop front), tdata the word to push. Each request
//   produces exactly one result transaction on m_axis: tdata carries the
//   popped word (zero for pushes and refused pops) and the occupancy after
//   the request, tuser the status (done, refused full, refused empty).
//   Storage is a row of DEPTH cells; cell 0 is always the front word, the
//   rear word sits in cell count-1. A front push shifts the row one cell up,
//   a front pop shifts it one cell down, rear operations touch one cell.
//   The result is captured in the output register at the accepting edge;
//   one request per cycle is sustained while the receiver does not stall,
//   set by the single shift step of the cell row.
//   s_axis_tready stays high while the output register is empty or being
//   drained in the same cycle; when the receiver stalls, the held result
//   keeps the chain frozen and back-pressure reaches the requester at once.
//   Reset empties the queue (count zero) and clears the output valid flag;
//   cell contents are not cleared and are never read before being written.
//
module double_ended_queue
    import dq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [WORD_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]  s_axis_tuser,   // [1:0] mode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [31:0] popped_value, [36:32] occupancy
    output logic [STATUS_W-1:0] m_axis_tuser   // [1:0] status
);

    `include "double_ended_queue_macros.svh"

    cnt_t    count_reg;
    cnt_t    count_next;
    logic    out_valid_reg;
    word_t   out_popped_reg;
    word_t   out_popped_next;
    status_t out_status_reg;
    status_t out_status_next;

    logic    in_fire;
    logic    is_full;
    logic    is_empty;
    logic    op_ok;
    word_t   rear_word;

    word_t      cell_data [DEPTH];
    word_t      cell_rd   [DEPTH];

    // A new request is taken when the result slot is free or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Rear word: AND-OR bus over the cells, the one at count-1 selected.
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | cell_rd[i];
        end
    end

    // Request decode: status, popped word, new count.
    always_comb
    begin
        out_status_next = ST_DONE;
        out_popped_next = '0;
        count_next      = count_reg;
        unique case (s_axis_tuser)
            MODE_PUSH_REAR, MODE_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP_REAR:
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_popped_next = rear_word;
                    count_next      = count_reg - 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_popped_next = cell_data[0];
                    count_next      = count_reg - 1'b1;
                end
            end
            default:
            begin
                out_status_next = ST_DONE;
            end
        endcase
    end

    assign op_ok = in_fire && (out_status_next == ST_DONE);

    // Cell chain: per-cell command and neighbor wiring.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t      left_in;
        word_t      right_in;
        cell_ctrl_t ctrl;

        if (i == 0)
        begin : g_first
            assign left_in = s_axis_tdata;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        always_comb
        begin
            ctrl.rd_sel = (count_reg == CNT_W'(i + 1));
            ctrl.cmd    = CMD_HOLD;
            if (op_ok)
            begin
                case (s_axis_tuser)
                    MODE_PUSH_REAR:
                    begin
                        if (count_reg == CNT_W'(i))
                        begin
                            ctrl.cmd = CMD_LOAD;
                        end
                    end
                    MODE_PUSH_FRONT: ctrl.cmd = CMD_TAKE_LEFT;
                    MODE_POP_FRONT:  ctrl.cmd = CMD_TAKE_RIGHT;
                    default:         ctrl.cmd = CMD_HOLD;
                endcase
            end
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_data  (s_axis_tdata),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_popped_reg <= out_popped_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(TDATA_W - WORD_W - OCC_W){1'b0}},
                            OCC_W'(count_reg), out_popped_reg};

    // Checks.
    `DQ_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "deque count above depth")
    `DQ_ASSERT_NEXT(a_full_refused, clk, rst_n,
        in_fire && !s_axis_tuser[1] && is_full,
        out_status_reg == ST_FULL && count_reg == CNT_W'(DEPTH),
        "push into full deque not refused")
    `DQ_ASSERT_NEXT(a_push_grows, clk, rst_n,
        in_fire && !s_axis_tuser[1] && !is_full,
        count_reg == $past(count_reg) + 1'b1 && out_status_reg == ST_DONE,
        "accepted push did not grow count")
    `DQ_ASSERT_NEXT(a_empty_pop_zero, clk, rst_n,
        in_fire && s_axis_tuser[1] && is_empty,
        out_status_reg == ST_EMPTY && out_popped_reg == '0 && count_reg == '0,
        "pop from empty deque not refused cleanly")

endmodule
